FILE: hw/rtl/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

    localparam int COEF_W     = 16;
    localparam int EXP_W      = 8;
    localparam int RCOEF_W    = 38;
    localparam int REXP_W     = 9;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    // How a travelling term treats a cell that already holds its exponent.
    localparam logic [1:0] KIND_APPEND = 2'd0;  // never matches
    localparam logic [1:0] KIND_MERGE  = 2'd1;  // adds into the match
    localparam logic [1:0] KIND_UNIQUE = 2'd2;  // vanishes on a match

    typedef struct packed {
        logic                      valid;
        logic [1:0]                kind;
        logic signed [RCOEF_W-1:0] coef;
        logic [REXP_W-1:0]         expo;
    } spa_token_t;

    typedef struct packed {
        logic                      valid;
        logic signed [RCOEF_W-1:0] coef;
        logic [REXP_W-1:0]         expo;
    } spa_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spa_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface spa_in_if import spa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [COEF_W-1:0] term_coefficient;
    logic [EXP_W-1:0]         term_exponent;

    modport source (output valid, opcode, term_coefficient, term_exponent, input ready);
    modport sink (input valid, opcode, term_coefficient, term_exponent, output ready);
endinterface

interface spa_out_if import spa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [RCOEF_W-1:0] result_coefficient;
    logic [REXP_W-1:0]         result_exponent;
    logic                      last_term;
    logic [1:0]                status;

    modport source (output valid, result_coefficient, result_exponent, last_term, status,
                    input ready);
    modport sink (input valid, result_coefficient, result_exponent, last_term, status,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spa_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_cell
    import spa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire spa_entry_t shift_in,
    input  wire spa_token_t tok_in,
    output spa_token_t      tok_out,
    output spa_entry_t      entry
);

    logic                      valid_reg, valid_next;
    logic signed [RCOEF_W-1:0] coef_reg, coef_next;
    logic [REXP_W-1:0]         expo_reg, expo_next;
    logic                      tok_valid_reg, tok_valid_next;
    spa_token_t                tok_reg;
    logic                      hit;

    assign hit = valid_reg && (expo_reg == tok_in.expo) && (tok_in.kind != KIND_APPEND);

    always_comb
    begin
        valid_next     = valid_reg;
        coef_next      = coef_reg;
        expo_next      = expo_reg;
        tok_valid_next = 1'b0;
        if (shift_en)
        begin
            valid_next = shift_in.valid;
            coef_next  = shift_in.coef;
            expo_next  = shift_in.expo;
        end
        else if (tok_in.valid)
        begin
            if (hit)
            begin
                if (tok_in.kind == KIND_MERGE)
                begin
                    coef_next = coef_reg + tok_in.coef;
                end
            end
            else if (!valid_reg)
            begin
                valid_next = 1'b1;
                coef_next  = tok_in.coef;
                expo_next  = tok_in.expo;
            end
            else
            begin
                tok_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        expo_reg <= expo_next;
        tok_reg  <= tok_in;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
        entry.valid   = valid_reg;
        entry.coef    = coef_reg;
        entry.expo    = expo_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sparse_polynomial_arithmetic.sv
`timescale 1ns / 1ps
`default_nettype none

// A compute walks every pair of A and B terms for multiply, or every pair and then
// each B term once more for add and subtract, then waits while the cell row settles,
// then gives one result item per cycle when out is ready.
// One item is worked at a time; the term walk and the settling of the row set the rate.
// rst_n is asynchronous and active low; it empties both stores and the result row.

module sparse_polynomial_arithmetic
    import spa_pkg::*;
#(
    parameter int MAX_TERMS        = 8,
    parameter int MAX_RESULT_TERMS = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    spa_in_if.sink     in_ch,
    spa_out_if.source  out_ch
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int DRN_W = $clog2(MAX_RESULT_TERMS + 2);
    localparam int N     = MAX_RESULT_TERMS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD_A = 3'd1;
    localparam logic [2:0] ST_ADD_B = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_ERR   = 3'd6;

    // Term stores: small register files read at the walk indices.
    logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
    logic [EXP_W-1:0]         a_exp  [MAX_TERMS];
    logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
    logic [EXP_W-1:0]         b_exp  [MAX_TERMS];

    logic [CNT_W-1:0] count_a_reg, count_b_reg;
    logic             dropped_reg, overflow_reg;
    logic [1:0]       mode_reg;
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic signed [COEF_W:0] acc_reg, acc_next;
    logic             found_reg, found_next;
    logic [DRN_W-1:0] drain_reg, drain_next;
    spa_token_t       tok_reg, tok_next;

    spa_token_t tok_chain [N+1];
    spa_entry_t entries   [N+1];
    logic       shift_en;

    logic in_fire, out_fire;
    logic last_i, last_j;
    logic signed [COEF_W-1:0] cur_a, cur_b;
    logic signed [COEF_W:0]   sum_cur;
    logic                     fnd_cur;
    logic signed [2*COEF_W-1:0] prod;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign last_i = ({{(CNT_W-IDX_W){1'b0}}, i_reg} == count_a_reg - 1'b1);
    assign last_j = ({{(CNT_W-IDX_W){1'b0}}, j_reg} == count_b_reg - 1'b1);
    assign cur_a  = a_coef[i_reg];
    assign cur_b  = b_coef[j_reg];
    assign prod   = cur_a * cur_b;

    // The cell row: a term enters cell 0 and moves one cell a cycle until it merges,
    // vanishes, claims the first empty cell or runs off the end. Results leave from cell 0.
    assign tok_chain[0] = tok_reg;
    assign entries[N]   = '0;
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cells
            spa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .shift_in (entries[g+1]),
                .tok_in   (tok_chain[g]),
                .tok_out  (tok_chain[g+1]),
                .entry    (entries[g])
            );
        end
    endgenerate

    assign shift_en = (state_reg == ST_EMIT) && out_fire;

    always_comb
    begin
        if (state_reg == ST_ERR)
        begin
            out_ch.valid              = 1'b1;
            out_ch.result_coefficient = '0;
            out_ch.result_exponent    = '0;
            out_ch.last_term          = 1'b1;
            out_ch.status             = STATUS_EMPTY;
        end
        else
        begin
            out_ch.valid              = (state_reg == ST_EMIT) && entries[0].valid;
            out_ch.result_coefficient = entries[0].coef;
            out_ch.result_exponent    = entries[0].expo;
            out_ch.last_term          = !entries[1].valid;
            out_ch.status             = (dropped_reg || overflow_reg) ? STATUS_DROPPED
                                                                       : STATUS_OK;
        end
    end

    // Add and subtract pair each A term with the first B term of equal exponent.
    always_comb
    begin
        sum_cur = (j_reg == '0) ? {cur_a[COEF_W-1], cur_a} : acc_reg;
        fnd_cur = (j_reg == '0) ? 1'b0 : found_reg;
        if (!fnd_cur && (b_exp[j_reg] == a_exp[i_reg]))
        begin
            fnd_cur = 1'b1;
            if (mode_reg == MODE_SUB)
            begin
                sum_cur = sum_cur - {cur_b[COEF_W-1], cur_b};
            end
            else
            begin
                sum_cur = sum_cur + {cur_b[COEF_W-1], cur_b};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        drain_next = drain_reg;
        tok_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                drain_next = '0;
                if (in_fire && (in_ch.opcode == OP_COMPUTE))
                begin
                    if ((count_a_reg == '0) || (count_b_reg == '0))
                    begin
                        state_next = ST_ERR;
                    end
                    else if (mode_reg == MODE_MUL)
                    begin
                        state_next = ST_MUL;
                    end
                    else if ((mode_reg == MODE_ADD) || (mode_reg == MODE_SUB))
                    begin
                        state_next = ST_ADD_A;
                    end
                end
            end
            ST_ADD_A:
            begin
                acc_next   = sum_cur;
                found_next = fnd_cur;
                if (last_j)
                begin
                    tok_next.valid = 1'b1;
                    tok_next.kind  = KIND_APPEND;
                    tok_next.coef  = RCOEF_W'(sum_cur);
                    tok_next.expo  = {1'b0, a_exp[i_reg]};
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (last_i)
                    begin
                        state_next = ST_ADD_B;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_ADD_B:
            begin
                tok_next.valid = 1'b1;
                tok_next.kind  = KIND_UNIQUE;
                tok_next.coef  = (mode_reg == MODE_SUB) ? -RCOEF_W'(cur_b) : RCOEF_W'(cur_b);
                tok_next.expo  = {1'b0, b_exp[j_reg]};
                j_next = j_reg + 1'b1;
                if (last_j)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_MUL:
            begin
                tok_next.valid = 1'b1;
                tok_next.kind  = KIND_MERGE;
                tok_next.coef  = RCOEF_W'(prod);
                tok_next.expo  = {1'b0, a_exp[i_reg]} + {1'b0, b_exp[j_reg]};
                if (last_j)
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (last_i)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Wait while the last terms move along the cell row and come to rest.
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRN_W'(N + 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && out_ch.last_term)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            dropped_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            mode_reg     <= MODE_ADD;
            tok_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            drain_reg    <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tok_reg   <= tok_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            drain_reg <= drain_next;
            found_reg <= found_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            // A term that runs off the end of the row found no room.
            if (tok_chain[N].valid)
            begin
                overflow_reg <= 1'b1;
            end
            if (in_fire)
            begin
                case (in_ch.opcode)
                    OP_LOAD_A:
                    begin
                        if (count_a_reg < CNT_W'(MAX_TERMS))
                        begin
                            count_a_reg <= count_a_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    OP_LOAD_B:
                    begin
                        if (count_b_reg < CNT_W'(MAX_TERMS))
                        begin
                            count_b_reg <= count_b_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_a_reg <= '0;
                        count_b_reg <= '0;
                        dropped_reg <= 1'b0;
                    end
                    default:
                    begin
                        overflow_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire && (in_ch.opcode == OP_LOAD_A) && (count_a_reg < CNT_W'(MAX_TERMS)))
        begin
            a_coef[count_a_reg[IDX_W-1:0]] <= in_ch.term_coefficient;
            a_exp[count_a_reg[IDX_W-1:0]]  <= in_ch.term_exponent;
        end
        if (in_fire && (in_ch.opcode == OP_LOAD_B) && (count_b_reg < CNT_W'(MAX_TERMS)))
        begin
            b_coef[count_b_reg[IDX_W-1:0]] <= in_ch.term_coefficient;
            b_exp[count_b_reg[IDX_W-1:0]]  <= in_ch.term_exponent;
        end
    end

`ifndef ASSERT_OFF
    // No new term may enter the row while results are leaving it.
    a_no_token_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !tok_reg.valid)
        else $error("term entered the cell row during emission");

    // Results appear only in the emission or error states.
    a_out_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((state_reg == ST_EMIT) || (state_reg == ST_ERR)))
        else $error("result offered outside emission");

    // A compute that starts a walk leaves the idle state on the next cycle.
    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.opcode == OP_COMPUTE) && (count_a_reg != '0)
         && (count_b_reg != '0) && (mode_reg != 2'd3)) |=> (state_reg != ST_IDLE))
        else $error("compute item did not start a walk");
`endif

endmodule

`default_nettype wire
